// File: hdl/atan_pkg.sv
// Shared types and constants for the arctan series unit.
// No dependencies; imported by every module of the block.
package atan_pkg;

    // Fixed-point format and term cap
    localparam int FRAC_BITS = 30;
    localparam int MAX_TERMS = 4096;
    localparam int X_W       = 32;
    localparam int TERM_W    = 13;
    localparam int STAT_W    = 2;
    localparam int MAG_W     = FRAC_BITS;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int THR_W     = FRAC_BITS + 1;
    localparam int DEC_DIGITS = 10;
    localparam int DCNT_W    = $clog2(MAG_W + 1);

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CAP   = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_CHECK,
        S_DIV,
        S_ACCUM,
        S_FINISH
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic square;
        logic div_start;
        logic accum;
        logic out_load;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic range_err;
        logic at_limit;
        logic div_done;
        logic acc_done;
        logic out_free;
    } sts_t;

    // Accuracy threshold: floor(2^FRAC_BITS / 10^digits), zero past nine digits
    function automatic logic [THR_W-1:0] thr_lookup(input logic [TERM_W-1:0] digits);
        logic [THR_W-1:0] one_fx;
        logic [THR_W-1:0] thr;
        one_fx = THR_W'(1) << FRAC_BITS;
        unique case (digits)
            TERM_W'(0): thr = one_fx;
            TERM_W'(1): thr = one_fx / THR_W'(10);
            TERM_W'(2): thr = one_fx / THR_W'(100);
            TERM_W'(3): thr = one_fx / THR_W'(1000);
            TERM_W'(4): thr = one_fx / THR_W'(10000);
            TERM_W'(5): thr = one_fx / THR_W'(100000);
            TERM_W'(6): thr = one_fx / THR_W'(1000000);
            TERM_W'(7): thr = one_fx / THR_W'(10000000);
            TERM_W'(8): thr = one_fx / THR_W'(100000000);
            TERM_W'(9): thr = one_fx / THR_W'(1000000000);
            default:    thr = '0;
        endcase
        return thr;
    endfunction

endpackage

// File: hdl/arctan_series_unit_top.sv
// Arctan series unit: sums x - x^3/3 + x^5/5 - ... in Q2.30 fixed point.
// Each term costs one bit-serial division plus check and accumulate steps, so the
// divider sets the pace. One request in flight at a time; a new request is taken
// once the previous result has moved into the output register. Up to 4096 terms
// per request. Reset (rst_n, async, active low) returns to idle and drops out_valid.
module arctan_series_unit_top
    import atan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [X_W-1:0]    x_value,
    input  logic              req_type,
    input  logic [TERM_W-1:0] count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [X_W-1:0]    atan_value,
    output logic [TERM_W-1:0] terms_used,
    output logic [STAT_W-1:0] status
);

    cmd_t cmd;
    sts_t sts;

    atan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atan_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .x_value    (x_value),
        .req_type   (req_type),
        .count      (count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .atan_value (atan_value),
        .terms_used (terms_used),
        .status     (status)
    );

endmodule

// File: hdl/atan_div.sv
// Bit-serial restoring divider: power magnitude over the odd term index.
// Depends on atan_pkg; one quotient bit per cycle.
module atan_div
    import atan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [TERM_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [MAG_W-1:0]  quotient
);

    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [TERM_W-1:0] rem_reg, rem_next;
    logic [TERM_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TERM_W:0]   rem_sh;
    logic [TERM_W:0]   rem_sub;

    // One restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[MAG_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DCNT_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[TERM_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[TERM_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and quotient flops
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/atan_dp.sv
// Datapath of the arctan series unit: operands, shared multiplier, divider,
// running sum and output register. Depends on atan_pkg and atan_div.
module atan_dp
    import atan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [X_W-1:0]    x_value,
    input  logic              req_type,
    input  logic [TERM_W-1:0] count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [X_W-1:0]    atan_value,
    output logic [TERM_W-1:0] terms_used,
    output logic [STAT_W-1:0] status
);

    logic [MAG_W-1:0]  m_reg;
    logic [MAG_W-1:0]  p_reg;
    logic [MAG_W-1:0]  x2_reg;
    logic              neg_reg;
    logic              range_reg;
    logic              mode_reg;
    logic [TERM_W-1:0] limit_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [TERM_W-1:0] n_reg;
    logic [X_W-1:0]    sum_reg;
    status_t           stat_reg;

    logic [X_W-1:0]    out_sum_reg;
    logic [TERM_W-1:0] out_terms_reg;
    status_t           out_stat_reg;
    logic              out_valid_reg, out_valid_next;

    logic              x_neg;
    logic [X_W-1:0]    x_mag;
    logic              x_range;
    logic              over_cap;
    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  t_val;
    logic [X_W-1:0]    t_ext;
    logic              t_neg;
    logic              t_small;
    logic              cap_hit;
    logic [TERM_W-1:0] divisor;
    logic              div_busy;
    logic              div_done;

    // Argument magnitude and range check
    assign x_neg    = x_value[X_W-1];
    assign x_mag    = x_neg ? (~x_value + X_W'(1)) : x_value;
    assign x_range  = |x_mag[X_W-1:FRAC_BITS];
    assign over_cap = count > TERM_W'(MAX_TERMS);

    // Shared multiplier: square first, then power update
    assign mul_a = cmd.square ? m_reg : p_reg;
    assign mul_b = cmd.square ? m_reg : x2_reg;
    assign prod  = mul_a * mul_b;

    // Odd index 2n+1; n stays below MAX_TERMS while dividing
    assign divisor = {n_reg[TERM_W-2:0], 1'b1};

    atan_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (p_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (t_val)
    );

    // Term sign alternates, starting from the sign of x
    assign t_ext   = {{(X_W-MAG_W){1'b0}}, t_val};
    assign t_neg   = neg_reg ^ n_reg[0];
    assign t_small = {1'b0, t_val} <= thr_reg;
    assign cap_hit = n_reg == TERM_W'(MAX_TERMS - 1);

    // Request operands and iteration state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg     <= x_mag[MAG_W-1:0];
            p_reg     <= x_mag[MAG_W-1:0];
            neg_reg   <= x_neg;
            range_reg <= x_range;
            mode_reg  <= req_type;
            thr_reg   <= thr_lookup(count);
            limit_reg <= (!req_type || over_cap) ? TERM_W'(MAX_TERMS) : count;
            n_reg     <= '0;
            sum_reg   <= '0;
            if (x_range)
                stat_reg <= ST_RANGE;
            else if (req_type && over_cap)
                stat_reg <= ST_CAP;
            else
                stat_reg <= ST_OK;
        end
        else if (cmd.square)
        begin
            x2_reg <= prod[PROD_W-1:FRAC_BITS];
        end
        else if (cmd.accum)
        begin
            sum_reg <= t_neg ? (sum_reg - t_ext) : (sum_reg + t_ext);
            n_reg   <= n_reg + TERM_W'(1);
            p_reg   <= prod[PROD_W-1:FRAC_BITS];
            if (!mode_reg && !t_small && cap_hit)
                stat_reg <= ST_CAP;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sum_reg   <= sum_reg;
            out_terms_reg <= n_reg;
            out_stat_reg  <= stat_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        sts.range_err = range_reg;
        sts.at_limit  = n_reg >= limit_reg;
        sts.div_done  = div_done;
        sts.acc_done  = !mode_reg && (t_small || cap_hit);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign atan_value = out_sum_reg;
    assign terms_used = out_terms_reg;
    assign status     = out_stat_reg;

    // Checks
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> n_reg < TERM_W'(MAX_TERMS))
        else $error("term counter past cap");

    a_div_idle_on_accum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> !div_busy)
        else $error("term used while divider busy");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stat_reg == ST_RANGE |-> out_sum_reg == '0 && out_terms_reg == '0)
        else $error("range error with nonzero result");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy && !div_done)
        else $error("divider did not start");

endmodule

// File: hdl/atan_ctrl.sv
// Controller of the arctan series unit: sequences load, square, divide and
// accumulate steps. Depends on atan_pkg.
module atan_ctrl
    import atan_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                state_next = sts.range_err ? S_FINISH : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.at_limit ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = sts.acc_done ? S_FINISH : S_CHECK;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SQUARE: cmd.square    = 1'b1;
            S_CHECK:  cmd.div_start = !sts.at_limit;
            S_DIV:    cmd           = '0;
            S_ACCUM:  cmd.accum     = 1'b1;
            S_FINISH: cmd.out_load  = sts.out_free;
            default:  cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: bench/arctan_series_unit_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for arctan_series_unit_top: a directed table, then random requests.
// Depends on atan_pkg (widths, status codes) and the arctan_series_unit_top RTL.
module arctan_series_unit_top_tb;
    import atan_pkg::*;

    localparam int N_DIR        = 21;
    localparam int N_RAND       = 80;
    localparam int N_TOTAL      = N_DIR + N_RAND;
    localparam int MAX_RAND_TRM = 160;        // keeps random requests short
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

    typedef enum logic {
        REQ_ACCURACY = 1'b0,
        REQ_TERMS    = 1'b1
    } req_mode_t;

    typedef struct packed {
        logic [X_W-1:0]    atan;
        logic [TERM_W-1:0] terms;
        status_t           st;
    } atan_res_t;

    typedef struct packed {
        logic [X_W-1:0]    x;
        req_mode_t         mode;
        logic [TERM_W-1:0] cnt;
        logic              typed;   // 1: use the typed result, 0: use the predictor
        atan_res_t         want;
    } stim_row_t;

    // Directed requests: range errors, zero count, smallest values, caps
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{32'h0000_0000, REQ_TERMS,    13'd0,    1'b1, '{32'h0000_0000, 13'd0,    ST_OK}},
        '{32'h4000_0000, REQ_TERMS,    13'd5,    1'b1, '{32'h0000_0000, 13'd0,    ST_RANGE}},
        '{32'hC000_0000, REQ_ACCURACY, 13'd3,    1'b1, '{32'h0000_0000, 13'd0,    ST_RANGE}},
        '{32'h8000_0000, REQ_TERMS,    13'd1,    1'b1, '{32'h0000_0000, 13'd0,    ST_RANGE}},
        '{32'h7FFF_FFFF, REQ_ACCURACY, 13'd9,    1'b1, '{32'h0000_0000, 13'd0,    ST_RANGE}},
        '{32'h5A5A_5A5A, REQ_ACCURACY, 13'h1555, 1'b1, '{32'h0000_0000, 13'd0,    ST_RANGE}},
        '{32'h0000_0000, REQ_ACCURACY, 13'd0,    1'b1, '{32'h0000_0000, 13'd1,    ST_OK}},
        '{32'h0000_0001, REQ_TERMS,    13'd3,    1'b1, '{32'h0000_0001, 13'd3,    ST_OK}},
        '{32'hFFFF_FFFF, REQ_TERMS,    13'd3,    1'b1, '{32'hFFFF_FFFF, 13'd3,    ST_OK}},
        '{32'h3FFF_FFFF, REQ_TERMS,    13'd1,    1'b1, '{32'h3FFF_FFFF, 13'd1,    ST_OK}},
        '{32'hC000_0001, REQ_TERMS,    13'd1,    1'b1, '{32'hC000_0001, 13'd1,    ST_OK}},
        '{32'h2000_0000, REQ_ACCURACY, 13'd0,    1'b1, '{32'h2000_0000, 13'd1,    ST_OK}},
        '{32'h2000_0000, REQ_ACCURACY, 13'd9,    1'b0, '0},
        '{32'hE000_0000, REQ_ACCURACY, 13'd10,   1'b0, '0},
        '{32'h3FFF_FFFF, REQ_ACCURACY, 13'd3,    1'b0, '0},
        '{32'hC000_0001, REQ_ACCURACY, 13'd1,    1'b0, '0},
        '{32'h1000_0000, REQ_TERMS,    13'd20,   1'b0, '0},
        '{32'hF000_0000, REQ_ACCURACY, 13'h0AAA, 1'b0, '0},
        '{32'h3FFF_FFFF, REQ_TERMS,    13'd4096, 1'b0, '0},
        '{32'h0000_0000, REQ_TERMS,    13'd8191, 1'b1, '{32'h0000_0000, 13'd4096, ST_CAP}},
        '{32'h3FFF_FFFF, REQ_ACCURACY, 13'd12,   1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [X_W-1:0]    x_value;
    logic              req_type;
    logic [TERM_W-1:0] count;
    logic              out_valid;
    logic              out_ready;
    logic [X_W-1:0]    atan_value;
    logic [TERM_W-1:0] terms_used;
    logic [STAT_W-1:0] status;

    atan_res_t expected_atan[$];
    int        mismatches;
    int        cycles;
    int        send_idle_pct;
    int        recv_idle_pct;

    arctan_series_unit_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_value    (x_value),
        .req_type   (req_type),
        .count      (count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .atan_value (atan_value),
        .terms_used (terms_used),
        .status     (status)
    );

    always #1 clk = ~clk;

    // Series sum on magnitudes, sign applied per term
    function automatic atan_res_t arctan_series(input logic [X_W-1:0] x, input req_mode_t mode,
                                                input logic [TERM_W-1:0] cnt);
        atan_res_t   r;
        logic        neg;
        logic [31:0] m32;
        logic [63:0] mag;
        logic [63:0] x2;
        logic [63:0] pw;
        logic [63:0] term;
        logic [63:0] thr;
        logic [63:0] lim;
        logic [63:0] n;
        logic [63:0] acc;
        status_t     st;
        neg = x[X_W-1];
        m32 = neg ? -x : x;
        mag = {32'd0, m32};
        if (mag >= ONE_FX)
        begin
            r = '{'0, '0, ST_RANGE};
            return r;
        end
        x2 = (mag * mag) >> FRAC_BITS;
        thr = '0;
        if (cnt <= 9)
        begin
            thr = ONE_FX;
            repeat (cnt) thr = thr / 10;
        end
        lim = (mode == REQ_TERMS) ? 64'(cnt) : 64'(MAX_TERMS);
        st = ST_OK;
        if (mode == REQ_TERMS && cnt > MAX_TERMS)
        begin
            lim = MAX_TERMS;
            st = ST_CAP;
        end
        pw = mag;
        acc = '0;
        n = '0;
        while (n < lim)
        begin
            term = pw / (2 * n + 1);
            if (neg ^ n[0])
                acc = acc - term;
            else
                acc = acc + term;
            n = n + 1;
            pw = (pw * x2) >> FRAC_BITS;
            if (mode == REQ_ACCURACY)
            begin
                if (term <= thr)
                    break;
                if (n >= MAX_TERMS)
                begin
                    st = ST_CAP;
                    break;
                end
            end
        end
        r.atan = acc[X_W-1:0];
        r.terms = n[TERM_W-1:0];
        r.st = st;
        return r;
    endfunction

    // Drive one request after a random gap and queue its expected result
    task automatic send_request(input logic [X_W-1:0] x, input req_mode_t mode,
                                input logic [TERM_W-1:0] cnt, input atan_res_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        req_type <= mode;
        count    <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        expected_atan.push_back(want);
    endtask

    // Random request: some noise, mostly in-range arguments of moderate cost
    task automatic pick_random(output logic [X_W-1:0] x, output req_mode_t mode,
                               output logic [TERM_W-1:0] cnt);
        logic [31:0] mag;
        atan_res_t   r;
        do
        begin
            mode = req_mode_t'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 20)
            begin
                x = $urandom;
                cnt = TERM_W'($urandom);
            end
            else
            begin
                mag = $urandom_range(0, (1 << FRAC_BITS) - 1);
                if ($urandom_range(0, 1))
                    mag = mag >> $urandom_range(0, 29);
                x = $urandom_range(0, 1) ? -mag : mag;
                if (mode == REQ_TERMS)
                    cnt = TERM_W'($urandom_range(0, 24));
                else if ($urandom_range(0, 1))
                    cnt = TERM_W'($urandom_range(0, 9));
                else
                    cnt = TERM_W'($urandom);
            end
            r = arctan_series(x, mode, cnt);
        end
        while (r.terms > MAX_RAND_TRM);
    endtask

    // Receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        atan_res_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_atan.size() == 0)
            begin
                $error("unexpected result: atan_value %h terms_used %0d status %0d",
                       atan_value, terms_used, status);
                mismatches++;
            end
            else
            begin
                exp_r = expected_atan.pop_front();
                if (atan_value !== exp_r.atan)
                begin
                    $error("atan_value: expected %h, got %h", exp_r.atan, atan_value);
                    mismatches++;
                end
                if (terms_used !== exp_r.terms)
                begin
                    $error("terms_used: expected %0d, got %0d", exp_r.terms, terms_used);
                    mismatches++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [X_W-1:0]    rx;
        req_mode_t         rmode;
        logic [TERM_W-1:0] rcnt;
        atan_res_t         want;
        int                k;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_value = '0;
        req_type = 1'b0;
        count = '0;
        out_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 53;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_TOTAL; k++)
        begin
            // three stall profiles: sender light, then receiver light, then none
            if (k < N_TOTAL / 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 53;
            end
            else if (k < 2 * N_TOTAL / 3)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (k < N_DIR)
            begin
                rx = DIR_ROWS[k].x;
                rmode = DIR_ROWS[k].mode;
                rcnt = DIR_ROWS[k].cnt;
                if (DIR_ROWS[k].typed)
                    want = DIR_ROWS[k].want;
                else
                    want = arctan_series(rx, rmode, rcnt);
            end
            else
            begin
                pick_random(rx, rmode, rcnt);
                want = arctan_series(rx, rmode, rcnt);
            end
            send_request(rx, rmode, rcnt, want);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain
        while (expected_atan.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
